FILE: design/host_command_frame_encoder_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the host command frame encoder
// Concurrent assertion wrappers that the design files share. Defining
// ASSERT_OFF turns every use into nothing.
// ----------------------------------------------------------------------------
`ifndef HOST_COMMAND_FRAME_ENCODER_TOP_ASSERT_SVH
`define HOST_COMMAND_FRAME_ENCODER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// The property must hold at every clock edge outside reset.
`define HCFE_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// The expression must never be true at a clock edge outside reset.
`define HCFE_ASSERT_NEVER(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define HCFE_ASSERT(name, clk, rst, prop, msg)
`define HCFE_ASSERT_NEVER(name, clk, rst, expr, msg)
`endif

`endif

FILE: design/hcfe_pkg.sv
// ----------------------------------------------------------------------------
// Host command frame encoder package
// Frame constants and the command record passed from front to back.
// ----------------------------------------------------------------------------
package hcfe_pkg;

   localparam logic [7:0] FRM_PREAMBLE  = 8'h00;
   localparam logic [7:0] FRM_START1    = 8'h00;
   localparam logic [7:0] FRM_START2    = 8'hFF;
   localparam logic [7:0] FRM_DIR_HOST  = 8'hD4;
   localparam logic [7:0] FRM_POSTAMBLE = 8'h00;
   localparam logic [7:0] FRM_MAX_COUNT = 8'd254;
   localparam logic [7:0] FRM_ALL_ONES  = 8'hFF;

   localparam int unsigned HCFE_QUEUE_DEPTH = 4;

   // One classified payload byte with everything the back end needs.
   typedef struct packed {
      logic [7:0] data;
      logic       first;
      logic       last;
      logic [7:0] count;
      logic [7:0] dcs;
   } hcfe_cmd_type;

endpackage

FILE: design/host_command_frame_encoder_top.sv
// Path: the first result of a transaction is registered in the command queue, then in the output register.
// Throughput: one input transaction per cycle while the queue has room; the sequencer emits one
// result per cycle unless stalled; an opening byte adds the header, a closing byte the trailer.
// The command queue lets the input side keep accepting while header and trailer bytes drain.
// Reset is synchronous and active high: no frame open, queue empty, no result pending.
// ----------------------------------------------------------------------------
// Host command frame encoder
// Wraps payload bytes in host-to-controller information frames with length
// and data checksums.
// ----------------------------------------------------------------------------
module host_command_frame_encoder_top #(
   parameter int unsigned QUEUE_DEPTH = hcfe_pkg::HCFE_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // Input transactions: one payload byte each.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] data_byte, [15:8] byte_count
   // Result transactions: one frame byte each.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] frame_byte
   output logic        rsp_tlast    // frame_end, set on the postamble
);
   import hcfe_pkg::*;

   // The front end classifies each byte against the open frame and computes
   // the running checksum, so every queued command is self contained.
   logic         push_valid, push_ready;
   hcfe_cmd_type push_cmd;
   // The back end pops commands and steps through the frame bytes that each
   // one expands to, holding results in its output register.
   logic         pop_valid, pop_ready;
   hcfe_cmd_type pop_cmd;

   hcfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_cmd)
   );

   hcfe_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_cmd)
   );

   hcfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (pop_valid),
      .cmd_ready  (pop_ready),
      .cmd        (pop_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: design/hcfe_fifo.sv
// ----------------------------------------------------------------------------
// Command queue
// Small register queue that decouples the classifier from the byte sequencer.
// ----------------------------------------------------------------------------
`include "host_command_frame_encoder_top_assert.svh"

module hcfe_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  hcfe_pkg::hcfe_cmd_type push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output hcfe_pkg::hcfe_cmd_type pop_data
);
   import hcfe_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   hcfe_cmd_type  mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `HCFE_ASSERT_NEVER(a_fifo_count_bound, clock, reset, count_ff > CW'(DEPTH), "queue count beyond depth")

endmodule

FILE: design/hcfe_front.sv
// ----------------------------------------------------------------------------
// Frame classifier
// Tracks the open frame, marks first and last bytes and folds the checksum.
// ----------------------------------------------------------------------------
`include "host_command_frame_encoder_top_assert.svh"

module hcfe_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,
   output logic                  push_valid,
   input  logic                  push_ready,
   output hcfe_pkg::hcfe_cmd_type push_data
);
   import hcfe_pkg::*;

   logic [7:0] bytes_remaining_ff, bytes_remaining_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic [7:0] data_byte, byte_count, count_sat;
   logic [7:0] rem_base, rem_next, sum_base, sum_next;
   logic       is_first, is_last, accept;

   assign data_byte  = req_tdata[7:0];
   assign byte_count = req_tdata[15:8];
   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign accept     = req_tvalid && push_ready;

   always_comb begin
      // A zero count frames a single byte; counts past the maximum saturate.
      if (byte_count == 8'd0) begin
         count_sat = 8'd1;
      end else if (byte_count > FRM_MAX_COUNT) begin
         count_sat = FRM_MAX_COUNT;
      end else begin
         count_sat = byte_count;
      end
      is_first = (bytes_remaining_ff == 8'd0);
      rem_base = is_first ? count_sat : bytes_remaining_ff;
      rem_next = rem_base - 8'd1;
      sum_base = is_first ? FRM_DIR_HOST : running_sum_ff;
      sum_next = sum_base + data_byte;
      is_last  = (rem_next == 8'd0);

      push_data.data  = data_byte;
      push_data.first = is_first;
      push_data.last  = is_last;
      push_data.count = count_sat;
      push_data.dcs   = 8'd0 - sum_next;

      bytes_remaining_in = bytes_remaining_ff;
      running_sum_in     = running_sum_ff;
      if (accept) begin
         bytes_remaining_in = rem_next;
         running_sum_in     = is_last ? 8'd0 : sum_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_remaining_ff <= 8'd0;
         running_sum_ff     <= 8'd0;
      end else begin
         bytes_remaining_ff <= bytes_remaining_in;
         running_sum_ff     <= running_sum_in;
      end
   end

   `HCFE_ASSERT(a_front_close, clock, reset, (accept && is_last) |=> (bytes_remaining_ff == 8'd0 && running_sum_ff == 8'd0), "frame did not close cleanly")

endmodule

FILE: design/hcfe_back.sv
// ----------------------------------------------------------------------------
// Frame byte sequencer
// Emits each data byte; a first adds the header, a last adds the trailer.
// ----------------------------------------------------------------------------
`include "host_command_frame_encoder_top_assert.svh"

module hcfe_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  hcfe_pkg::hcfe_cmd_type cmd,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tlast
);
   import hcfe_pkg::*;

   typedef enum logic [3:0] {
      PH_NEXT, PH_PRE, PH_START1, PH_START2, PH_LEN, PH_LCS,
      PH_DIR, PH_DATA, PH_DCS, PH_POST
   } phase_type;

   phase_type  phase_ff, phase_in, phase_now;
   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_end_ff;
   logic [7:0] byte_sel;
   logic       advance, done;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_end_ff;

   always_comb begin
      // A fresh command starts with the header only if it opens a frame.
      if (phase_ff == PH_NEXT) begin
         phase_now = cmd.first ? PH_PRE : PH_DATA;
      end else begin
         phase_now = phase_ff;
      end

      advance = cmd_valid && (!rsp_valid_ff || rsp_tready);
      done    = (phase_now == PH_POST) || (phase_now == PH_DATA && !cmd.last);
      cmd_ready = advance && done;

      unique case (phase_now)
         PH_PRE:    byte_sel = FRM_PREAMBLE;
         PH_START1: byte_sel = FRM_START1;
         PH_START2: byte_sel = FRM_START2;
         PH_LEN:    byte_sel = cmd.count + 8'd1;
         PH_LCS:    byte_sel = FRM_ALL_ONES - cmd.count;
         PH_DIR:    byte_sel = FRM_DIR_HOST;
         PH_DATA:   byte_sel = cmd.data;
         PH_DCS:    byte_sel = cmd.dcs;
         PH_POST:   byte_sel = FRM_POSTAMBLE;
         default:   byte_sel = cmd.data;
      endcase

      phase_in = phase_ff;
      if (advance) begin
         if (done) begin
            phase_in = PH_NEXT;
         end else begin
            unique case (phase_now)
               PH_PRE:    phase_in = PH_START1;
               PH_START1: phase_in = PH_START2;
               PH_START2: phase_in = PH_LEN;
               PH_LEN:    phase_in = PH_LCS;
               PH_LCS:    phase_in = PH_DIR;
               PH_DIR:    phase_in = PH_DATA;
               PH_DATA:   phase_in = PH_DCS;
               PH_DCS:    phase_in = PH_POST;
               default:   phase_in = PH_NEXT;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_NEXT;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            rsp_byte_ff  <= byte_sel;
            rsp_end_ff   <= (phase_now == PH_POST);
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   `HCFE_ASSERT(a_back_post_end, clock, reset, (advance && phase_now == PH_POST) |=> (rsp_valid_ff && rsp_end_ff), "postamble not marked as frame end")

endmodule
